/* rtl/core/pku_pkg.sv */
// pku_pkg: shared types, constants and helpers of the particle keyframe update block
// life stage record, step and action codes, controller/datapath command and status
// no dependencies
package pku_pkg;

	localparam int MAX_STAGES_DEF = 8;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int SW             = 72;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	localparam logic REG_MAX_AGE     = 1'b0;
	localparam logic REG_STAGE_COUNT = 1'b1;

	typedef struct packed {
		logic signed [31:0] age;
		logic signed [31:0] size;
		logic signed [31:0] alpha;
		logic signed [31:0] speed;
		logic signed [31:0] gravity;
		logic signed [31:0] rot;
		logic [7:0]         colour;
		logic               rnd;
	} stage_t;

	localparam int STAGE_W = $bits(stage_t);

	typedef enum logic [3:0] {
		STEP_G, STEP_DIRY, STEP_RS, STEP_ANG, STEP_SPD, STEP_ALPHA, STEP_SIZE,
		STEP_VX, STEP_PX, STEP_VY, STEP_PY, STEP_VZ, STEP_PZ
	} step_t;

	typedef struct packed {
		logic  div_start_age;
		logic  div_start_t;
		logic  age_upd;
		logic  latch_prev;
		logic  latch_next;
		logic  t_clear;
		logic  t_load;
		logic  mul;
		logic  acc;
		logic  out_load;
		step_t step;
	} pku_cmd_t;

	typedef struct packed {
		logic div_done;
		logic dead;
		logic age_le;
		logic diff_zero;
		logic out_free;
	} pku_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
		logic signed [31:0] r;
		if ((&v[SW-1:31]) || !(|v[SW-1:31]))
			r = v[31:0];
		else if (v[SW-1])
			r = 32'sh80000000;
		else
			r = 32'sh7FFFFFFF;
		return r;
	endfunction

endpackage

/* rtl/core/pku_ram.sv */
// pku_ram: generic single write port, single read port ram with registered read
// no dependencies
module pku_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/core/pku_div.sv */
// pku_div: restoring signed divider, one quotient bit per cycle, truncates toward zero
// result saturated to 32 bits; depends on pku_pkg
module pku_div #(
	parameter int FRAC_BITS = pku_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [34+FRAC_BITS-1:0] num,
	input  logic signed [32:0]          den,
	output logic                        done,
	output logic signed [31:0]          q
);
	localparam int NUMW = 34 + FRAC_BITS;
	localparam int NW   = NUMW - 1;
	localparam int CNTW = $clog2(NW + 1);

	logic              busy_q;
	logic [CNTW-1:0]   cnt_q;
	logic [32:0]       rem_q;
	logic [NW-1:0]     quo_q;
	logic [32:0]       den_q;
	logic              neg_q;
	logic              done_q;
	logic [NUMW-1:0]   num_abs;
	logic [32:0]       den_abs;
	logic [33:0]       rem_sh;
	logic              ge;

	assign num_abs = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
	assign den_abs = den[32] ? 33'(-den) : 33'(den);
	assign rem_sh  = {rem_q, quo_q[NW-1]};
	assign ge      = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNTW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num_abs[NW-1:0];
			den_q <= den_abs;
			neg_q <= num[NUMW-1] ^ den[32];
		end else if (busy_q) begin
			rem_q <= ge ? 33'(rem_sh - {1'b0, den_q}) : rem_sh[32:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	always_comb begin
		if (!neg_q)
			q = (quo_q > NW'(64'h7FFFFFFF)) ? 32'sh7FFFFFFF : quo_q[31:0];
		else
			q = (quo_q > NW'(64'h80000000)) ? 32'sh80000000 : -quo_q[31:0];
	end

	assign done = done_q;
endmodule

/* rtl/core/pku_dp.sv */
// pku_dp: datapath with stage ram, particle state, shared multiplier and divider
// result register; depends on pku_pkg, pku_ram, pku_div
module pku_dp #(
	parameter int MAX_STAGES = pku_pkg::MAX_STAGES_DEF,
	parameter int FRAC_BITS  = pku_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_acc,
	input  logic [1:0]               action,
	input  logic [2:0]               stage_index,
	input  logic signed [31:0]       dt_or_age,
	input  logic signed [31:0]       value_a,
	input  logic signed [31:0]       value_b,
	input  logic signed [31:0]       value_c,
	input  logic signed [31:0]       value_d,
	input  logic signed [31:0]       value_e,
	input  logic signed [31:0]       value_f,
	input  logic [7:0]               colour_row_in,
	input  logic                     rotation_random,
	input  logic [30:0]              max_age,
	input  pku_pkg::pku_cmd_t        cmd,
	input  logic [(MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1)-1:0] rd_addr,
	output pku_pkg::pku_stat_t       stat,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     alive,
	output logic signed [31:0]       pos_x,
	output logic signed [31:0]       pos_y,
	output logic signed [31:0]       pos_z,
	output logic signed [31:0]       angle_out,
	output logic signed [31:0]       size_out,
	output logic signed [31:0]       alpha_out,
	output logic [7:0]               colour_first,
	output logic [7:0]               colour_second,
	output logic signed [31:0]       colour_blend
);
	import pku_pkg::*;

	localparam int AW   = MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1;
	localparam int NUMW = 34 + FRAC_BITS;
	localparam logic signed [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

	logic signed [31:0] age_q, ang_q, t_q, tmp_q, spd_q, alpha_q, size_q, dt_q;
	logic signed [31:0] dir_q [3];
	logic signed [31:0] pos_q [3];
	stage_t             prv_q, nxt_q, rd_stage;
	logic [STAGE_W-1:0] rdata;
	logic               we;
	logic [31:0]        idx32;
	stage_t             wr_stage;
	logic signed [65:0] prod_s1;
	logic signed [32:0] opa, opb;
	logic signed [31:0] addend;
	logic               sat_inner;
	logic signed [SW-1:0] prod_w, shifted, inner, ntmp;
	logic signed [31:0] acc_res;
	logic signed [NUMW-1:0] div_num;
	logic signed [32:0] div_den;
	logic               div_start, div_done;
	logic signed [31:0] div_q;
	logic               out_valid_q;

	assign idx32 = 32'(stage_index);
	assign we    = in_acc && (action == ACT_LOAD) && (idx32 < 32'(MAX_STAGES));
	assign wr_stage = '{age: dt_or_age, size: value_a, alpha: value_b, speed: value_c,
		gravity: value_d, rot: value_e, colour: colour_row_in, rnd: rotation_random};

	pku_ram #(.WIDTH(STAGE_W), .DEPTH(MAX_STAGES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx32[AW-1:0]),
		.wdata (wr_stage),
		.raddr (rd_addr),
		.rdata (rdata)
	);
	assign rd_stage = stage_t'(rdata);

	always_comb begin
		if (cmd.div_start_age) begin
			div_num = NUMW'(SW'(dt_q) <<< FRAC_BITS);
			div_den = (max_age == '0) ? 33'sd1 : signed'({2'b00, max_age});
		end else begin
			div_num = NUMW'(SW'(33'(age_q) - 33'(prv_q.age)) <<< FRAC_BITS);
			div_den = 33'(nxt_q.age) - 33'(prv_q.age);
		end
	end
	assign div_start = cmd.div_start_age | cmd.div_start_t;

	pku_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.q      (div_q)
	);

	assign ntmp = -SW'(tmp_q);

	always_comb begin
		opa       = '0;
		opb       = 33'(dt_q);
		addend    = '0;
		sat_inner = 1'b1;
		case (cmd.step)
			STEP_G: begin
				opa = 33'(nxt_q.gravity) - 33'(prv_q.gravity);
				opb = 33'(t_q);
				addend = prv_q.gravity;
				sat_inner = 1'b0;
			end
			STEP_DIRY: begin
				opa = 33'(sat32(ntmp));
				addend = dir_q[1];
			end
			STEP_RS: begin
				opa = 33'(nxt_q.rot) - 33'(prv_q.rot);
				opb = 33'(t_q);
				addend = prv_q.rot;
				sat_inner = 1'b0;
			end
			STEP_ANG: begin
				opa = 33'(tmp_q);
				addend = ang_q;
			end
			STEP_SPD: begin
				opa = 33'(nxt_q.speed) - 33'(prv_q.speed);
				opb = 33'(t_q);
				addend = prv_q.speed;
				sat_inner = 1'b0;
			end
			STEP_ALPHA: begin
				opa = 33'(nxt_q.alpha) - 33'(prv_q.alpha);
				opb = 33'(t_q);
				addend = prv_q.alpha;
				sat_inner = 1'b0;
			end
			STEP_SIZE: begin
				opa = 33'(nxt_q.size) - 33'(prv_q.size);
				opb = 33'(t_q);
				addend = prv_q.size;
				sat_inner = 1'b0;
			end
			STEP_VX: begin
				opa = 33'(dir_q[0]);
				opb = 33'(spd_q);
			end
			STEP_PX: begin
				opa = 33'(tmp_q);
				addend = pos_q[0];
			end
			STEP_VY: begin
				opa = 33'(dir_q[1]);
				opb = 33'(spd_q);
			end
			STEP_PY: begin
				opa = 33'(tmp_q);
				addend = pos_q[1];
			end
			STEP_VZ: begin
				opa = 33'(dir_q[2]);
				opb = 33'(spd_q);
			end
			STEP_PZ: begin
				opa = 33'(tmp_q);
				addend = pos_q[2];
			end
			default: begin
				opa = '0;
			end
		endcase
	end

	assign prod_w  = SW'(prod_s1);
	assign shifted = prod_w >>> FRAC_BITS;
	assign inner   = sat_inner ? SW'(sat32(shifted)) : shifted;
	assign acc_res = sat32(SW'(addend) + inner);

	// particle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
			ang_q <= '0;
			for (int i = 0; i < 3; i++) begin
				dir_q[i] <= '0;
				pos_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc && action == ACT_START) begin
				age_q    <= '0;
				pos_q[0] <= value_a;
				pos_q[1] <= value_b;
				pos_q[2] <= value_c;
				dir_q[0] <= value_d;
				dir_q[1] <= value_e;
				dir_q[2] <= value_f;
			end
			if (cmd.age_upd) begin
				age_q <= sat32(SW'(age_q) + SW'(div_q));
			end
			if (cmd.acc) begin
				case (cmd.step)
					STEP_DIRY: dir_q[1] <= acc_res;
					STEP_ANG: begin
						if (prv_q.rnd) begin
							ang_q <= acc_res;
						end
					end
					STEP_PX: pos_q[0] <= acc_res;
					STEP_PY: pos_q[1] <= acc_res;
					STEP_PZ: pos_q[2] <= acc_res;
					default: ;
				endcase
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && action == ACT_TICK) begin
			dt_q <= dt_or_age;
		end
		if (cmd.latch_prev) begin
			prv_q <= rd_stage;
		end
		if (cmd.latch_next) begin
			nxt_q <= rd_stage;
		end
		if (cmd.t_clear) begin
			t_q <= '0;
		end else if (cmd.t_load) begin
			t_q <= div_q;
		end
		if (cmd.mul) begin
			prod_s1 <= opa * opb;
		end
		if (cmd.acc) begin
			case (cmd.step)
				STEP_G, STEP_RS, STEP_VX, STEP_VY, STEP_VZ: tmp_q <= acc_res;
				STEP_SPD:   spd_q   <= acc_res;
				STEP_ALPHA: alpha_q <= acc_res;
				STEP_SIZE:  size_q  <= acc_res;
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			if (stat.dead) begin
				alive         <= 1'b0;
				pos_x         <= '0;
				pos_y         <= '0;
				pos_z         <= '0;
				angle_out     <= '0;
				size_out      <= '0;
				alpha_out     <= '0;
				colour_first  <= '0;
				colour_second <= '0;
				colour_blend  <= '0;
			end else begin
				alive         <= 1'b1;
				pos_x         <= pos_q[0];
				pos_y         <= pos_q[1];
				pos_z         <= pos_q[2];
				angle_out     <= ang_q;
				size_out      <= size_q;
				alpha_out     <= alpha_q;
				colour_first  <= prv_q.colour;
				colour_second <= nxt_q.colour;
				colour_blend  <= t_q;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign stat.div_done  = div_done;
	assign stat.dead      = age_q > ONE_Q;
	assign stat.age_le    = rd_stage.age <= age_q;
	assign stat.diff_zero = nxt_q.age == prv_q.age;
	assign stat.out_free  = !out_valid_q || !out_stall;
endmodule

/* rtl/core/pku_ctrl.sv */
// pku_ctrl: sequencer for one tick: age division, stage search, blend division, mac steps
// depends on pku_pkg
module pku_ctrl #(
	parameter int MAX_STAGES = pku_pkg::MAX_STAGES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_acc,
	input  logic [3:0]           stage_count,
	input  pku_pkg::pku_stat_t   stat,
	output pku_pkg::pku_cmd_t    cmd,
	output logic [(MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1)-1:0] rd_addr,
	output logic                 busy
);
	import pku_pkg::*;

	localparam int AW = MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1;
	localparam int CW = $clog2(MAX_STAGES + 1);

	typedef enum logic [14:0] {
		S_IDLE     = 15'b000000000000001,
		S_AGE_GO   = 15'b000000000000010,
		S_AGE_DIV  = 15'b000000000000100,
		S_AGE_UPD  = 15'b000000000001000,
		S_LIFE     = 15'b000000000010000,
		S_SRCH_RD  = 15'b000000000100000,
		S_SRCH_CHK = 15'b000000001000000,
		S_FETCH_P  = 15'b000000010000000,
		S_FETCH_N  = 15'b000000100000000,
		S_LATCH_N  = 15'b000001000000000,
		S_T_GO     = 15'b000010000000000,
		S_T_DIV    = 15'b000100000000000,
		S_MUL      = 15'b001000000000000,
		S_ACC      = 15'b010000000000000,
		S_FINISH   = 15'b100000000000000
	} state_t;

	state_t         state_q, state_d;
	step_t          step_q;
	logic [CW-1:0]  p_q, p_inc, n_eff;
	logic [31:0]    sc32;
	logic           has_next;

	assign sc32     = 32'(stage_count);
	assign n_eff    = (sc32 == 32'd0) ? CW'(1) :
		(sc32 > 32'(MAX_STAGES)) ? CW'(MAX_STAGES) : CW'(sc32);
	assign p_inc    = p_q + CW'(1);
	assign has_next = p_inc < n_eff;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.step = step_q;
		rd_addr = p_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (tick_acc) state_d = S_AGE_GO;
			end
			S_AGE_GO: begin
				cmd.div_start_age = 1'b1;
				state_d = S_AGE_DIV;
			end
			S_AGE_DIV: begin
				if (stat.div_done) state_d = S_AGE_UPD;
			end
			S_AGE_UPD: begin
				cmd.age_upd = 1'b1;
				state_d = S_LIFE;
			end
			S_LIFE: begin
				state_d = stat.dead ? S_FINISH : S_SRCH_RD;
			end
			S_SRCH_RD: begin
				rd_addr = p_inc[AW-1:0];
				state_d = has_next ? S_SRCH_CHK : S_FETCH_P;
			end
			S_SRCH_CHK: begin
				state_d = stat.age_le ? S_SRCH_RD : S_FETCH_P;
			end
			S_FETCH_P: begin
				state_d = S_FETCH_N;
			end
			S_FETCH_N: begin
				cmd.latch_prev = 1'b1;
				rd_addr = has_next ? p_inc[AW-1:0] : p_q[AW-1:0];
				state_d = S_LATCH_N;
			end
			S_LATCH_N: begin
				cmd.latch_next = 1'b1;
				state_d = S_T_GO;
			end
			S_T_GO: begin
				if (has_next && !stat.diff_zero) begin
					cmd.div_start_t = 1'b1;
					state_d = S_T_DIV;
				end else begin
					cmd.t_clear = 1'b1;
					state_d = S_MUL;
				end
			end
			S_T_DIV: begin
				if (stat.div_done) begin
					cmd.t_load = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = (step_q == STEP_PZ) ? S_FINISH : S_MUL;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= STEP_G;
			p_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_LIFE) begin
				p_q <= '0;
			end else if (state_q == S_SRCH_CHK && stat.age_le) begin
				p_q <= p_inc;
			end
			if (state_q == S_T_GO || state_q == S_T_DIV) begin
				step_q <= STEP_G;
			end else if (state_q == S_ACC && step_q != STEP_PZ) begin
				step_q <= step_t'(step_q + 4'd1);
			end
		end
	end

	assign busy = state_q != S_IDLE;
endmodule

/* rtl/core/particle_keyframe_update.sv */
// particle_keyframe_update: top level, configuration registers, controller and datapath
// depends on pku_pkg, pku_ctrl, pku_dp
//
//   channel   direction  handshake            beat
//   cfg       in         psel/penable/pready  max_age, stage_count
//   in        in         in_valid/in_stall    action, stage slot, operands
//   out       out        out_valid/out_stall  alive, position, angle, size, alpha, colour
//
// load and start beats never stall the input, the block stays ready
// a tick stalls the input from accept until its result enters the output register, paced by
// the bit-serial divider used up to twice and the shared multiplier stepped over 13 products
// a dead particle skips the search, blend and products
// the result waits in an output register; a stalled output holds only the next tick
// reset: age, direction, position, angle cleared; stage table holds garbage until loaded
module particle_keyframe_update #(
	parameter int MAX_STAGES = pku_pkg::MAX_STAGES_DEF,
	parameter int FRAC_BITS  = pku_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [2:0]         stage_index,
	input  logic signed [31:0] dt_or_age,
	input  logic signed [31:0] value_a,
	input  logic signed [31:0] value_b,
	input  logic signed [31:0] value_c,
	input  logic signed [31:0] value_d,
	input  logic signed [31:0] value_e,
	input  logic signed [31:0] value_f,
	input  logic [7:0]         colour_row_in,
	input  logic               rotation_random,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               alive,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [31:0] angle_out,
	output logic signed [31:0] size_out,
	output logic signed [31:0] alpha_out,
	output logic [7:0]         colour_first,
	output logic [7:0]         colour_second,
	output logic signed [31:0] colour_blend
);
	import pku_pkg::*;

	localparam int AW = MAX_STAGES > 1 ? $clog2(MAX_STAGES) : 1;

	logic [30:0] max_age_q;
	logic [3:0]  stage_count_q;
	logic        in_acc, busy;
	pku_cmd_t    cmd;
	pku_stat_t   stat;
	logic [AW-1:0] rd_addr;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q     <= 31'd65536;
			stage_count_q <= 4'd1;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_MAX_AGE:     max_age_q     <= pwdata[30:0];
				REG_STAGE_COUNT: stage_count_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_AGE:     prdata = {1'b0, max_age_q};
			REG_STAGE_COUNT: prdata = {28'd0, stage_count_q};
			default:         prdata = '0;
		endcase
	end

	assign in_stall = busy;
	assign in_acc   = in_valid && !in_stall;

	pku_ctrl #(.MAX_STAGES(MAX_STAGES)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_acc    (in_acc && action == ACT_TICK),
		.stage_count (stage_count_q),
		.stat        (stat),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.busy        (busy)
	);

	pku_dp #(.MAX_STAGES(MAX_STAGES), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_acc          (in_acc),
		.action          (action),
		.stage_index     (stage_index),
		.dt_or_age       (dt_or_age),
		.value_a         (value_a),
		.value_b         (value_b),
		.value_c         (value_c),
		.value_d         (value_d),
		.value_e         (value_e),
		.value_f         (value_f),
		.colour_row_in   (colour_row_in),
		.rotation_random (rotation_random),
		.max_age         (max_age_q),
		.cmd             (cmd),
		.rd_addr         (rd_addr),
		.stat            (stat),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.alive           (alive),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.angle_out       (angle_out),
		.size_out        (size_out),
		.alpha_out       (alpha_out),
		.colour_first    (colour_first),
		.colour_second   (colour_second),
		.colour_blend    (colour_blend)
	);
endmodule

/* rtl/core/pku_checker.sv */
// pku_checker: port-level assertions for the particle keyframe update block
// bound to particle_keyframe_update; depends on pku_pkg
module pku_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         action,
	input logic               out_valid,
	input logic               out_stall,
	input logic               alive,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] size_out,
	input logic signed [31:0] colour_blend
);
	import pku_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == ACT_TICK |=> in_stall)
		else $error("tick beat did not start work");

	a_quick_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action != ACT_TICK |=> !in_stall)
		else $error("load or start beat stalled the input");

	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !alive |-> pos_x == 0 && size_out == 0 && colour_blend == 0)
		else $error("dead result carries data");
endmodule

bind particle_keyframe_update pku_checker u_pku_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.action       (action),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.alive        (alive),
	.pos_x        (pos_x),
	.size_out     (size_out),
	.colour_blend (colour_blend)
);

/* sim/tb_top.sv */
// tb_top: self-checking testbench of particle_keyframe_update
// drives stage loads, starts and ticks, predicts each tick result and checks it
// depends on pku_pkg and the particle_keyframe_update rtl
`timescale 1ns / 100ps

module tb_top;
	import pku_pkg::*;

	localparam int IDLE_LIMIT  = 20000;
	localparam int SETTLE_CYC  = 250;
	localparam int LONG_HOLD   = 2500;
	localparam longint ONE_Q   = 65536;

	typedef struct {
		logic [1:0]         act;
		logic [2:0]         slot;
		logic signed [31:0] dt;
		logic signed [31:0] va, vb, vc, vd, ve, vf;
		logic [7:0]         colour;
		logic               rnd;
	} beat_t;

	typedef struct {
		logic               alive;
		logic signed [31:0] pos_x, pos_y, pos_z, angle, size, alpha;
		logic [7:0]         col_a, col_b;
		logic signed [31:0] blend;
	} tick_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = ACT_LOAD;
	logic [2:0] stage_index = '0;
	logic signed [31:0] dt_or_age = '0, value_a = '0, value_b = '0, value_c = '0;
	logic signed [31:0] value_d = '0, value_e = '0, value_f = '0;
	logic [7:0] colour_row_in = '0;
	logic rotation_random = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic alive;
	logic signed [31:0] pos_x, pos_y, pos_z, angle_out, size_out, alpha_out, colour_blend;
	logic [7:0] colour_first, colour_second;

	// predictor state
	stage_t stage_tab [8];
	longint age_q, angle_q;
	longint dir_q [3];
	longint pos_q [3];
	logic [30:0] max_age_cfg;
	logic [3:0] stage_count_cfg;

	tick_result_t tick_q [$];
	int errors = 0;
	int idle_cycles = 0;
	bit no_idle = 0;
	bit hold_req = 0;
	bit hold_busy = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	particle_keyframe_update i_dut (.*);

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return clamp32((a * b) >>> 16);
	endfunction

	function automatic longint blend(longint a, longint b, longint t);
		return clamp32(a + (((b - a) * t) >>> 16));
	endfunction

	function automatic tick_result_t advance_particle(logic signed [31:0] dt);
		tick_result_t r;
		longint dv, ndt, t, g, rs, spd, v, diff;
		int n, p;
		stage_t prv, nxt;
		r = '{default: '0};
		dv = (max_age_cfg == 0) ? 1 : longint'(max_age_cfg);
		ndt = clamp32((longint'(dt) * ONE_Q) / dv);
		age_q = clamp32(age_q + ndt);
		if (age_q > ONE_Q) return r;
		n = stage_count_cfg;
		if (n == 0) n = 1;
		if (n > 8) n = 8;
		p = 0;
		while (p + 1 < n && longint'(stage_tab[p+1].age) <= age_q) p++;
		prv = stage_tab[p];
		nxt = prv;
		t = 0;
		if (p + 1 < n) begin
			nxt = stage_tab[p+1];
			diff = longint'(nxt.age) - longint'(prv.age);
			if (diff != 0) t = clamp32(((age_q - longint'(prv.age)) * ONE_Q) / diff);
		end
		g = blend(prv.gravity, nxt.gravity, t);
		dir_q[1] = clamp32(dir_q[1] + qmul(clamp32(-g), dt));
		if (prv.rnd) begin
			rs = blend(prv.rot, nxt.rot, t);
			angle_q = clamp32(angle_q + qmul(rs, dt));
		end
		spd = blend(prv.speed, nxt.speed, t);
		for (int i = 0; i < 3; i++) begin
			v = qmul(dir_q[i], spd);
			pos_q[i] = clamp32(pos_q[i] + qmul(v, dt));
		end
		r.alive = 1'b1;
		r.pos_x = pos_q[0];
		r.pos_y = pos_q[1];
		r.pos_z = pos_q[2];
		r.angle = angle_q;
		r.size  = blend(prv.size, nxt.size, t);
		r.alpha = blend(prv.alpha, nxt.alpha, t);
		r.col_a = prv.colour;
		r.col_b = nxt.colour;
		r.blend = t;
		return r;
	endfunction

	function automatic void apply_beat(beat_t b);
		if (b.act == ACT_LOAD) begin
			stage_tab[b.slot] = '{age: b.dt, size: b.va, alpha: b.vb, speed: b.vc,
				gravity: b.vd, rot: b.ve, colour: b.colour, rnd: b.rnd};
		end else if (b.act == ACT_START) begin
			pos_q[0] = b.va; pos_q[1] = b.vb; pos_q[2] = b.vc;
			dir_q[0] = b.vd; dir_q[1] = b.ve; dir_q[2] = b.vf;
			age_q = 0;
		end else if (b.act == ACT_TICK) begin
			tick_q.insert(tick_q.size(), advance_particle(b.dt));
		end
	endfunction

	task automatic send_beat(beat_t b);
		int gap;
		action <= b.act; stage_index <= b.slot; dt_or_age <= b.dt;
		value_a <= b.va; value_b <= b.vb; value_c <= b.vc;
		value_d <= b.vd; value_e <= b.ve; value_f <= b.vf;
		colour_row_in <= b.colour; rotation_random <= b.rnd;
		in_valid <= 1'b1;
		do @(negedge clk); while (in_stall);
		apply_beat(b);
		@(posedge clk);
		gap = 0;
		if (!no_idle) begin
			case ($urandom_range(0, 9))
				0, 1, 2: gap = $urandom_range(1, 3);
				3:       gap = $urandom_range(10, 40);
				default: gap = 0;
			endcase
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic reg_write(logic reg_sel, logic [31:0] data);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00}; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (reg_sel == REG_MAX_AGE) max_age_cfg = data[30:0];
		else stage_count_cfg = data[3:0];
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tick_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_config(logic [31:0] age_lim, logic [31:0] count);
		settle();
		reg_write(REG_MAX_AGE, age_lim);
		reg_write(REG_STAGE_COUNT, count);
	endtask

	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(0, 7))
			0:       return $urandom();
			1:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
		endcase
	endfunction

	function automatic beat_t mk_beat(logic [1:0] act);
		beat_t b;
		b.act = act; b.slot = 3'($urandom()); b.dt = rand_q();
		b.va = rand_q(); b.vb = rand_q(); b.vc = rand_q();
		b.vd = rand_q(); b.ve = rand_q(); b.vf = rand_q();
		b.colour = 8'($urandom()); b.rnd = 1'($urandom());
		return b;
	endfunction

	task automatic load_ramp();
		int ages [$];
		beat_t b;
		for (int i = 0; i < 8; i++) begin
			if ($urandom_range(0, 5) == 0)
				ages.insert(ages.size(), $urandom_range(0, 4) * 16384);
			else
				ages.insert(ages.size(), $urandom_range(0, 65536));
		end
		ages.sort();
		if ($urandom_range(0, 1)) ages[0] = 0;
		for (int i = 0; i < 8; i++) begin
			b = mk_beat(ACT_LOAD);
			b.slot = 3'(i);
			b.dt = ages[i];
			send_beat(b);
		end
	endtask

	function automatic logic signed [31:0] rand_dt();
		longint hi;
		hi = longint'(max_age_cfg == 0 ? 1 : max_age_cfg) / 6;
		if (hi > 64'sd2147483647) hi = 64'sd2147483647;
		case ($urandom_range(0, 11))
			0:       return $urandom();
			1:       return 32'(-$signed({1'b0, $urandom_range(0, 1000)}));
			default: return $urandom_range(0, int'(hi));
		endcase
	endfunction

	// mostly start + tick runs with random content, some noise
	task automatic random_flights(int ticks);
		beat_t b;
		int done = 0;
		while (done < ticks) begin
			if ($urandom_range(0, 4) == 0) load_ramp();
			send_beat(mk_beat(ACT_START));
			repeat ($urandom_range(1, 12)) begin
				if ($urandom_range(0, 15) == 0) begin
					b = mk_beat(2'($urandom()));
					send_beat(b);
					if (b.act == ACT_TICK) done++;
				end else begin
					b = mk_beat(ACT_TICK);
					b.dt = rand_dt();
					send_beat(b);
					done++;
				end
			end
		end
	endtask

	task automatic test_basic_flight();
		beat_t b;
		load_ramp();
		b = mk_beat(ACT_START);
		send_beat(b);
		repeat (4) begin
			b = mk_beat(ACT_TICK);
			b.dt = 16384;
			send_beat(b);
		end
	endtask

	task automatic test_corner_cases();
		beat_t b;
		set_config(32'h0001_0000, 8);
		// equal ages, extreme stage values, both rotation kinds
		for (int i = 0; i < 8; i++) begin
			b = mk_beat(ACT_LOAD);
			b.slot = 3'(i);
			b.dt = (i < 3) ? 0 : i * 8192;
			b.va = (i % 2) ? 32'sh7FFFFFFF : 32'sh80000000;
			b.vd = (i % 2) ? 32'sh80000000 : 32'sh7FFFFFFF;
			b.colour = (i % 2) ? 8'hFF : 8'h00;
			b.rnd = 1'(i % 2);
			send_beat(b);
		end
		b = mk_beat(ACT_START);
		b.va = 32'sh7FFFFFFF; b.vb = 32'sh80000000; b.vc = 0;
		b.vd = 32'sh80000000; b.ve = 32'sh7FFFFFFF; b.vf = -1;
		send_beat(b);
		b = mk_beat(ACT_TICK); b.dt = 0; send_beat(b);
		b.dt = 60000; send_beat(b);
		b.dt = 5536; send_beat(b);
		b.dt = 1; send_beat(b);
		b.dt = 32'sh7FFFFFFF; send_beat(b);
		b.dt = 32'sh80000000; send_beat(b);
		b = mk_beat(ACT_START); b.act = 2'd3; send_beat(b);
		b = mk_beat(ACT_TICK); b.dt = -100; send_beat(b);
		// count out of range and zero lifetime
		set_config(0, 0);
		send_beat(mk_beat(ACT_START));
		b = mk_beat(ACT_TICK); b.dt = 0; send_beat(b);
		b.dt = 1; send_beat(b);
		b.dt = 2; send_beat(b);
		set_config(32'h7FFF_FFFF, 15);
		send_beat(mk_beat(ACT_START));
		b = mk_beat(ACT_TICK); b.dt = 32'sh7FFFFFFF; send_beat(b);
		send_beat(b);
	endtask

	task automatic test_config_sweep();
		set_config(32'h0002_0000, 4);
		random_flights(150);
		set_config(32'h7FFF_FFFF, 8);
		random_flights(100);
		set_config(1, 8);
		random_flights(80);
		set_config(32'h0000_4000, 1);
		no_idle = 1;
		random_flights(80);
		no_idle = 0;
		set_config(32'h0001_0000, 6);
		random_flights(150);
	endtask

	task automatic test_backpressure();
		beat_t b;
		hold_req = 1;
		wait (hold_busy);
		send_beat(mk_beat(ACT_START));
		repeat (6) begin
			b = mk_beat(ACT_TICK);
			b.dt = rand_dt();
			send_beat(b);
		end
		wait (!hold_busy);
	endtask

	task automatic test_drain_pause();
		beat_t b;
		send_beat(mk_beat(ACT_START));
		b = mk_beat(ACT_TICK); b.dt = rand_dt(); send_beat(b);
		in_valid <= 1'b0;
		@(posedge clk);
		while (tick_q.size() != 0) @(posedge clk);
		b.dt = rand_dt(); send_beat(b);
		random_flights(40);
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		static int stall_left = 0;
		static int hold_left = 0;
		if (hold_req) begin
			hold_req = 0;
			hold_left = LONG_HOLD;
			hold_busy = 1;
		end
		if (hold_left > 0) begin
			hold_left--;
			if (hold_left == 0) hold_busy = 0;
			out_stall <= 1'b1;
		end else if (no_idle) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			case ($urandom_range(0, 15))
				0, 1, 2: begin stall_left = $urandom_range(0, 3); out_stall <= 1'b1; end
				3:       begin stall_left = $urandom_range(20, 300); out_stall <= 1'b1; end
				default: out_stall <= 1'b0;
			endcase
		end
	end

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(negedge clk) begin
		tick_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (tick_q.size() == 0) begin
				$error("result beat with no tick outstanding");
				errors++;
			end else begin
				e = tick_q.pop_front();
				check_field("alive", e.alive, alive);
				check_field("pos_x", e.pos_x, pos_x);
				check_field("pos_y", e.pos_y, pos_y);
				check_field("pos_z", e.pos_z, pos_z);
				check_field("angle_out", e.angle, angle_out);
				check_field("size_out", e.size, size_out);
				check_field("alpha_out", e.alpha, alpha_out);
				check_field("colour_first", e.col_a, colour_first);
				check_field("colour_second", e.col_b, colour_second);
				check_field("colour_blend", e.blend, colour_blend);
			end
		end
	end

	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("particle_keyframe_update test failed");
			$finish;
		end
	end

	initial begin
		foreach (stage_tab[i]) stage_tab[i] = '0;
		age_q = 0; angle_q = 0;
		foreach (dir_q[i]) begin dir_q[i] = 0; pos_q[i] = 0; end
		max_age_cfg = 31'd65536;
		stage_count_cfg = 4'd1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_flight();
		test_corner_cases();
		test_config_sweep();
		test_backpressure();
		test_drain_pause();
		settle();
		if (errors == 0)
			$display("particle_keyframe_update test passed");
		else
			$display("particle_keyframe_update test failed");
		$finish;
	end

endmodule
